/* src/glqd_pkg.sv */
// Shared types and constants for the gray level quantizer with dither.
// No dependencies; every other file of the block but glqd_ram uses it by scoped name.
package glqd_pkg;

    localparam int GRAY_BITS  = 8;
    localparam int NOISE_BITS = 4;
    localparam int COL_BITS   = 12;
    localparam int WIDTH_BITS = 13;
    localparam int LEVEL_BITS = 9;
    localparam int CFG_BITS   = 13;
    localparam int CFG_IDX_BITS = 2;

    localparam int GRAY_DEPTH = 256;
    localparam int MAX_WIDTH  = 4096;

    localparam logic [GRAY_BITS-1:0]  GRAY_MAX     = 8'd255;
    localparam logic [9:0]            TWO_GRAY_MAX = 10'd510;
    localparam logic [WIDTH_BITS-1:0] WIDTH_MAX    = 13'd4096;
    localparam logic [LEVEL_BITS-1:0] LEVEL_MIN    = 9'd2;
    localparam logic [LEVEL_BITS-1:0] LEVEL_MAX    = 9'd256;
    localparam logic [LEVEL_BITS-1:0] LEVEL_RESET  = 9'd2;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_BITS-1:0] REG_LEVEL_COUNT   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_DITHER_ENABLE = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH   = 2'd2;

    // Table write port from the builder
    typedef struct packed {
        logic                 en;
        logic [GRAY_BITS-1:0] addr;
        logic [GRAY_BITS-1:0] data;
    } wr_t;

endpackage

/* src/glqd_if.sv */
// Stream interfaces for the quantizer: input pixel words and result words.
// Depends on glqd_pkg for field widths.
interface glqd_pix_if;
    logic                                valid;
    logic                                ready;
    logic [glqd_pkg::GRAY_BITS-1:0]      pixel_in;
    logic [glqd_pkg::NOISE_BITS-1:0]     noise_value;
    logic                                frame_start;

    modport source (output valid, output pixel_in, output noise_value,
                    output frame_start, input ready);
    modport sink   (input valid, input pixel_in, input noise_value,
                    input frame_start, output ready);
endinterface

interface glqd_out_if;
    logic                           valid;
    logic                           ready;
    logic [glqd_pkg::GRAY_BITS-1:0] pixel_out;

    modport source (output valid, output pixel_out, input ready);
    modport sink   (input valid, input pixel_out, output ready);
endinterface

/* src/gray_level_quantizer_dither.sv */
// Top level of the gray level quantizer with checkerboard noise dither.
// Depends on glqd_pkg, glqd_if, glqd_ram, glqd_builder and glqd_position.
//
//  channel  dir  handshake          payload
//  pix      in   valid / ready      pixel_in[7:0] noise_value[3:0] frame_start
//  quant    out  valid / ready      pixel_out[7:0]
//  cfg      in   cfg_we             cfg_index[1:0] cfg_data[12:0]
//
// One pixel per clock while no rebuild runs and no result is stalled; a result
// shows in the cycle after its pixel, read from the level table RAM through
// its registered port. After reset and after each level_count write the table
// is rebuilt (a start cycle, then a sweep over the gray values that writes each
// once its output level has settled), during which pix.ready is low.
// A stalled result holds in the RAM read register; pix.ready also drops
// while that result waits.
module gray_level_quantizer_dither (
    input  logic                                 clk,
    input  logic                                 rst_n,
    glqd_pix_if.sink                             pix,
    glqd_out_if.source                           quant,
    input  logic                                 cfg_we,
    input  logic [glqd_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [glqd_pkg::CFG_BITS-1:0]        cfg_data
);

    logic [glqd_pkg::LEVEL_BITS-1:0] level_count_reg;
    logic                            dither_enable_reg;
    logic [glqd_pkg::WIDTH_BITS-1:0] image_width_reg;
    logic                            start_reg;
    logic                            result_valid_reg;

    logic [glqd_pkg::GRAY_BITS-1:0]  step_count;
    logic [glqd_pkg::WIDTH_BITS-1:0] width_eff;
    logic [glqd_pkg::GRAY_BITS-1:0]  index;
    logic                            accept;
    logic                            build_busy;
    glqd_pkg::wr_t                   wr;

    always_comb
    begin
        if (level_count_reg < glqd_pkg::LEVEL_MIN)
        begin
            step_count = 8'd1;
        end
        else if (level_count_reg > glqd_pkg::LEVEL_MAX)
        begin
            step_count = glqd_pkg::GRAY_MAX;
        end
        else
        begin
            step_count = 8'(level_count_reg - 9'd1);
        end
    end

    always_comb
    begin
        if (image_width_reg == '0)
        begin
            width_eff = 13'd1;
        end
        else if (image_width_reg > glqd_pkg::WIDTH_MAX)
        begin
            width_eff = glqd_pkg::WIDTH_MAX;
        end
        else
        begin
            width_eff = image_width_reg;
        end
    end

    assign pix.ready = !build_busy && !start_reg && (!result_valid_reg || quant.ready);
    assign accept    = pix.valid && pix.ready;
    assign quant.valid = result_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_count_reg   <= glqd_pkg::LEVEL_RESET;
            dither_enable_reg <= 1'b0;
            image_width_reg   <= 13'd1;
            start_reg         <= 1'b1;
            result_valid_reg  <= 1'b0;
        end
        else
        begin
            // rebuild the table after every level_count write
            start_reg <= cfg_we && (cfg_index == glqd_pkg::REG_LEVEL_COUNT);
            if (cfg_we)
            begin
                unique case (cfg_index)
                    glqd_pkg::REG_LEVEL_COUNT:
                    begin
                        level_count_reg <= cfg_data[glqd_pkg::LEVEL_BITS-1:0];
                    end
                    glqd_pkg::REG_DITHER_ENABLE:
                    begin
                        dither_enable_reg <= cfg_data[0];
                    end
                    glqd_pkg::REG_IMAGE_WIDTH:
                    begin
                        image_width_reg <= cfg_data;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (accept)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (quant.ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    glqd_position u_position (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (accept),
        .pixel_in      (pix.pixel_in),
        .noise_value   (pix.noise_value),
        .frame_start   (pix.frame_start),
        .dither_enable (dither_enable_reg),
        .image_width   (width_eff),
        .index         (index)
    );

    glqd_builder u_builder (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start_reg),
        .step_count (step_count),
        .wr         (wr),
        .busy       (build_busy)
    );

    glqd_ram #(
        .WIDTH (glqd_pkg::GRAY_BITS),
        .DEPTH (glqd_pkg::GRAY_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (wr.en),
        .waddr (wr.addr),
        .wdata (wr.data),
        .re    (accept),
        .raddr (index),
        .rdata (quant.pixel_out)
    );

endmodule

/* src/glqd_ram.sv */
// Generic simple dual port RAM: one write port, one registered read port.
// No dependencies.
module glqd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // hold read data until the next read
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* src/glqd_builder.sv */
// Level table builder: sweeps all gray values and writes the quantized level.
// Depends on glqd_pkg. Rounding quotients are kept as running remainders.
module glqd_builder (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [glqd_pkg::GRAY_BITS-1:0] step_count,
    output glqd_pkg::wr_t                  wr,
    output logic                           busy
);

    typedef enum logic {B_IDLE, B_SWEEP} state_t;

    state_t                         state_reg;
    logic [glqd_pkg::GRAY_BITS-1:0] step_reg;
    logic [glqd_pkg::GRAY_BITS-1:0] gray_reg;
    logic [9:0]                     krem_reg;
    logic [8:0]                     oquo_reg;
    logic [9:0]                     orem_reg;

    logic [9:0] two_step;
    logic [9:0] krem_sum;
    logic       settled;

    assign two_step = {1'b0, step_reg, 1'b0};
    assign krem_sum = krem_reg + two_step;
    // output quotient is final once the remainder is below the divisor
    assign settled  = (orem_reg < two_step);

    assign busy     = (state_reg == B_SWEEP);
    assign wr.en    = busy && settled;
    assign wr.addr  = gray_reg;
    assign wr.data  = oquo_reg[8] ? glqd_pkg::GRAY_MAX : oquo_reg[7:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            step_reg  <= '0;
            gray_reg  <= '0;
            krem_reg  <= '0;
            oquo_reg  <= '0;
            orem_reg  <= '0;
        end
        else if (start)
        begin
            // k numerator starts at M, output numerator at s
            state_reg <= B_SWEEP;
            step_reg  <= step_count;
            gray_reg  <= '0;
            krem_reg  <= {2'b00, glqd_pkg::GRAY_MAX};
            oquo_reg  <= '0;
            orem_reg  <= {2'b00, step_count};
        end
        else
        begin
            unique case (state_reg)
                B_IDLE:
                begin
                    state_reg <= B_IDLE;
                end
                B_SWEEP:
                begin
                    if (!settled)
                    begin
                        orem_reg <= orem_reg - two_step;
                        oquo_reg <= oquo_reg + 9'd1;
                    end
                    else if (gray_reg == glqd_pkg::GRAY_MAX)
                    begin
                        state_reg <= B_IDLE;
                    end
                    else
                    begin
                        gray_reg <= gray_reg + 8'd1;
                        // advance k by at most one level per gray step
                        if (krem_sum >= glqd_pkg::TWO_GRAY_MAX)
                        begin
                            krem_reg <= krem_sum - glqd_pkg::TWO_GRAY_MAX;
                            orem_reg <= orem_reg + glqd_pkg::TWO_GRAY_MAX;
                        end
                        else
                        begin
                            krem_reg <= krem_sum;
                        end
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule

/* src/glqd_position.sv */
// Raster position tracker and noise dither; yields the table read address.
// Depends on glqd_pkg.
module glqd_position (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             advance,
    input  logic [glqd_pkg::GRAY_BITS-1:0]   pixel_in,
    input  logic [glqd_pkg::NOISE_BITS-1:0]  noise_value,
    input  logic                             frame_start,
    input  logic                             dither_enable,
    input  logic [glqd_pkg::WIDTH_BITS-1:0]  image_width,
    output logic [glqd_pkg::GRAY_BITS-1:0]   index
);

    logic [glqd_pkg::COL_BITS-1:0]   column_reg;
    logic                            row_odd_reg;
    logic [glqd_pkg::COL_BITS-1:0]   column_cur;
    logic                            row_cur;
    logic [glqd_pkg::WIDTH_BITS-1:0] column_inc;
    logic [glqd_pkg::GRAY_BITS:0]    sum;
    logic [glqd_pkg::GRAY_BITS-1:0]  noise_ext;

    assign column_cur = frame_start ? '0 : column_reg;
    assign row_cur    = frame_start ? 1'b0 : row_odd_reg;
    assign column_inc = {1'b0, column_cur} + 13'd1;
    assign noise_ext  = {4'b0000, noise_value};
    assign sum        = {1'b0, pixel_in} + {1'b0, noise_ext};

    always_comb
    begin
        index = pixel_in;
        if (dither_enable)
        begin
            if (row_cur ^ column_cur[0])
            begin
                index = sum[8] ? glqd_pkg::GRAY_MAX : sum[7:0];
            end
            else
            begin
                index = (pixel_in > noise_ext) ? (pixel_in - noise_ext) : '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg  <= '0;
            row_odd_reg <= 1'b0;
        end
        else if (advance)
        begin
            // wrap at the end of a row, also when the width shrank mid-row
            if (column_inc >= image_width)
            begin
                column_reg  <= '0;
                row_odd_reg <= ~row_cur;
            end
            else
            begin
                column_reg  <= column_inc[glqd_pkg::COL_BITS-1:0];
                row_odd_reg <= row_cur;
            end
        end
    end

endmodule
